// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int HALF_W   = 16;
    localparam int TOCFG_W  = 24;
    localparam int LIMIT_W  = 32;
    localparam int PHASE_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW   = 24;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;

    localparam logic [HALF_W-1:0]  HALF_RESET    = 16'd5;
    localparam logic [TOCFG_W-1:0] TIMEOUT_RESET = 24'd50000;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_BUSWAIT    = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_STRETCH = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST_D1      = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST_D2      = 5'd4;
    localparam logic [PHASE_W-1:0] PH_W_D1       = 5'd5;
    localparam logic [PHASE_W-1:0] PH_W_STRETCH  = 5'd6;
    localparam logic [PHASE_W-1:0] PH_W_D2       = 5'd7;
    localparam logic [PHASE_W-1:0] PH_A_D1       = 5'd8;
    localparam logic [PHASE_W-1:0] PH_A_STRETCH  = 5'd9;
    localparam logic [PHASE_W-1:0] PH_R_D1       = 5'd10;
    localparam logic [PHASE_W-1:0] PH_R_STRETCH  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RA_D1      = 5'd12;
    localparam logic [PHASE_W-1:0] PH_RA_STRETCH = 5'd13;
    localparam logic [PHASE_W-1:0] PH_RA_D2      = 5'd14;
    localparam logic [PHASE_W-1:0] PH_P_D1       = 5'd15;
    localparam logic [PHASE_W-1:0] PH_P_D2       = 5'd16;

    // command flag bit positions
    localparam int FL_READ  = 0;
    localparam int FL_START = 1;
    localparam int FL_STOP  = 2;
    localparam int FL_ACK   = 3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic       action;
        logic [7:0] tx_byte;
        logic       with_start;
        logic       with_stop;
        logic       ack_after_read;
        logic       scl_in;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
    } res_t;

    typedef struct packed {
        logic [HALF_W-1:0]  half_period;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

endpackage

// ===== rtl/i2c_master_byte_engine_top.sv =====
// I2C master byte engine, one timebase tick per input beat, one result beat per tick.
// Instantiates i2cm_cfg and i2cm_core; uses i2cm_pkg.
`timescale 1ns / 1ps

// Each input beat is one timebase tick carrying the sampled SCL/SDA levels and an optional
// byte command; each tick yields exactly one result beat with the line drives, busy, done,
// status and last received byte as they stand after that tick. The sequencer state advances
// through combinational next-state logic and the result lands in an output register in the
// cycle after acceptance; a tick is taken every clock cycle whenever the result side keeps
// up. Commands arriving while busy are ignored. Configuration writes take effect on the next
// cycle and must only happen while the engine is idle.

module i2c_master_byte_engine_top
    import i2cm_pkg::*;
#(
    parameter int TIMEOUT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd_valid,
    input  logic                 s_action,
    input  logic [7:0]           s_tx_byte,
    input  logic                 s_with_start,
    input  logic                 s_with_stop,
    input  logic                 s_ack_after_read,
    input  logic                 s_scl_in,
    input  logic                 s_sda_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scl_out,
    output logic                 m_sda_out,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [1:0]           m_status,
    output logic [7:0]           m_rx_byte
);

    cfg_t  cfg;
    tick_t tick;
    res_t  res;
    res_t  out_reg;
    logic  m_valid_reg;
    logic  step;

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    assign tick.cmd_valid      = s_cmd_valid;
    assign tick.action         = s_action;
    assign tick.tx_byte        = s_tx_byte;
    assign tick.with_start     = s_with_start;
    assign tick.with_stop      = s_with_stop;
    assign tick.ack_after_read = s_ack_after_read;
    assign tick.scl_in         = s_scl_in;
    assign tick.sda_in         = s_sda_in;

    i2cm_cfg #(
        .TIMEOUT_BITS(TIMEOUT_BITS)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    i2cm_core #(
        .TIMEOUT_BITS(TIMEOUT_BITS)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .tick   (tick),
        .cfg    (cfg),
        .res    (res)
    );

    // hold the result beat until taken; refill in the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_scl_out  = out_reg.scl_out;
    assign m_sda_out  = out_reg.sda_out;
    assign m_busy_res = out_reg.busy_res;
    assign m_done_res = out_reg.done_res;
    assign m_status   = out_reg.status;
    assign m_rx_byte  = out_reg.rx_byte;

endmodule

// ===== rtl/i2cm_cfg.sv =====
// Configuration registers of the I2C master byte engine.
// Holds the half period and the timeout, clamped to the wait counter range. Uses i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_cfg
    import i2cm_pkg::*;
#(
    parameter int TIMEOUT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    localparam logic [LIMIT_W-1:0] TO_MASK = LIMIT_W'((64'd1 << TIMEOUT_BITS) - 64'd1);

    logic [HALF_W-1:0]  half_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] wr_ext;
    logic [LIMIT_W-1:0] rst_ext;

    assign wr_ext  = LIMIT_W'(cfg_wdata[TOCFG_W-1:0]);
    assign rst_ext = LIMIT_W'(TIMEOUT_RESET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= HALF_RESET;
            limit_reg <= (rst_ext > TO_MASK) ? TO_MASK : rst_ext;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_HALF_PERIOD) begin
                half_reg <= cfg_wdata[HALF_W-1:0];
            end
            if (cfg_index == REG_TIMEOUT) begin
                limit_reg <= (wr_ext > TO_MASK) ? TO_MASK : wr_ext;
            end
        end
    end

    assign cfg.half_period = half_reg;
    assign cfg.limit       = limit_reg;

endmodule

// ===== rtl/i2cm_core.sv =====
// Byte sequencer of the I2C master engine: state registers and one-tick next-state logic.
// Uses i2cm_pkg; configuration comes from i2cm_cfg.
`timescale 1ns / 1ps

module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int TIMEOUT_BITS = 24
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  tick_t tick,
    input  cfg_t  cfg,
    output res_t  res
);

    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [3:0]              bitcnt_reg, bitcnt_next;
    logic [7:0]              sh_reg, sh_next;
    logic [HALF_W-1:0]       delay_reg, delay_next;
    logic [TIMEOUT_BITS-1:0] wait_reg, wait_next;
    logic [3:0]              flags_reg, flags_next;
    logic                    scl_reg, scl_next;
    logic                    sda_reg, sda_next;
    logic [1:0]              last_reg, last_next;
    logic [1:0]              pend_reg, pend_next;
    logic [7:0]              rx_reg, rx_next;

    logic [TIMEOUT_BITS-1:0] wait_inc;
    logic                    wait_exp;
    logic                    delay_done;
    logic [3:0]              bitcnt_inc;
    logic                    fin;
    logic [1:0]              fin_status;

    assign wait_inc   = wait_reg + 1'b1;
    assign wait_exp   = LIMIT_W'(wait_inc) >= cfg.limit;
    assign delay_done = delay_reg <= HALF_W'(1);
    assign bitcnt_inc = bitcnt_reg + 4'd1;

    always_comb begin
        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        sh_next     = sh_reg;
        delay_next  = delay_reg;
        wait_next   = wait_reg;
        flags_next  = flags_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        last_next   = last_reg;
        pend_next   = pend_reg;
        rx_next     = rx_reg;
        fin         = 1'b0;
        fin_status  = ST_OK;

        // every delay phase counts down or finishes this tick
        if (!delay_done) begin
            delay_next = delay_reg - HALF_W'(1);
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (tick.cmd_valid) begin
                    bitcnt_next = 4'd0;
                    flags_next  = {tick.ack_after_read, tick.with_stop,
                                   tick.with_start, tick.action};
                    if (tick.action) begin
                        sh_next    = 8'd0;
                        sda_next   = 1'b1;
                        delay_next = cfg.half_period;
                        phase_next = PH_R_D1;
                    end else begin
                        sh_next = tick.tx_byte;
                        if (tick.with_start) begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            wait_next  = '0;
                            phase_next = PH_BUSWAIT;
                        end else begin
                            sda_next   = tick.tx_byte[7];
                            delay_next = cfg.half_period;
                            phase_next = PH_W_D1;
                        end
                    end
                end
            end
            PH_BUSWAIT: begin
                if (tick.sda_in) begin
                    scl_next   = 1'b1;
                    wait_next  = '0;
                    phase_next = PH_ST_STRETCH;
                end else begin
                    wait_next = wait_inc;
                    if (wait_exp) begin
                        fin        = 1'b1;
                        fin_status = ST_TIMEOUT;
                    end
                end
            end
            PH_ST_STRETCH, PH_W_STRETCH, PH_A_STRETCH, PH_R_STRETCH, PH_RA_STRETCH: begin
                if (tick.scl_in) begin
                    unique case (phase_reg)
                        PH_ST_STRETCH: begin
                            sda_next   = 1'b0;
                            delay_next = cfg.half_period;
                            phase_next = PH_ST_D1;
                        end
                        PH_W_STRETCH: begin
                            delay_next = cfg.half_period;
                            phase_next = PH_W_D2;
                        end
                        PH_A_STRETCH: begin
                            scl_next = 1'b0;
                            if (flags_reg[FL_STOP] || tick.sda_in) begin
                                pend_next  = tick.sda_in ? ST_NACK : ST_OK;
                                sda_next   = 1'b0;
                                delay_next = cfg.half_period;
                                phase_next = PH_P_D1;
                            end else begin
                                fin        = 1'b1;
                                fin_status = ST_OK;
                            end
                        end
                        PH_R_STRETCH: begin
                            sh_next     = {sh_reg[6:0], tick.sda_in};
                            scl_next    = 1'b0;
                            bitcnt_next = bitcnt_inc;
                            delay_next  = cfg.half_period;
                            if (bitcnt_inc >= BITS_PER_BYTE) begin
                                sda_next   = !flags_reg[FL_ACK];
                                phase_next = PH_RA_D1;
                            end else begin
                                phase_next = PH_R_D1;
                            end
                        end
                        default: begin
                            delay_next = cfg.half_period;
                            phase_next = PH_RA_D2;
                        end
                    endcase
                end else begin
                    wait_next = wait_inc;
                    if (wait_exp) begin
                        // stretch timeout: issue a stop and report it
                        pend_next  = ST_TIMEOUT;
                        sda_next   = 1'b0;
                        delay_next = cfg.half_period;
                        phase_next = PH_P_D1;
                    end
                end
            end
            PH_ST_D1: begin
                if (delay_done) begin
                    delay_next = cfg.half_period;
                    scl_next   = 1'b0;
                    phase_next = PH_ST_D2;
                end
            end
            PH_ST_D2: begin
                if (delay_done) begin
                    sda_next   = sh_reg[7];
                    delay_next = cfg.half_period;
                    phase_next = PH_W_D1;
                end
            end
            PH_W_D1, PH_A_D1, PH_R_D1, PH_RA_D1: begin
                if (delay_done) begin
                    delay_next = '0;
                    scl_next   = 1'b1;
                    wait_next  = '0;
                    unique case (phase_reg)
                        PH_W_D1: phase_next = PH_W_STRETCH;
                        PH_A_D1: phase_next = PH_A_STRETCH;
                        PH_R_D1: phase_next = PH_R_STRETCH;
                        default: phase_next = PH_RA_STRETCH;
                    endcase
                end
            end
            PH_W_D2: begin
                if (delay_done) begin
                    scl_next    = 1'b0;
                    sh_next     = {sh_reg[6:0], 1'b0};
                    bitcnt_next = bitcnt_inc;
                    delay_next  = cfg.half_period;
                    if (bitcnt_inc >= BITS_PER_BYTE) begin
                        sda_next   = 1'b1;
                        phase_next = PH_A_D1;
                    end else begin
                        sda_next   = sh_reg[6];
                        phase_next = PH_W_D1;
                    end
                end
            end
            PH_RA_D2: begin
                if (delay_done) begin
                    delay_next = '0;
                    scl_next   = 1'b0;
                    rx_next    = sh_reg;
                    if (flags_reg[FL_STOP]) begin
                        pend_next  = ST_OK;
                        sda_next   = 1'b0;
                        delay_next = cfg.half_period;
                        phase_next = PH_P_D1;
                    end else begin
                        fin        = 1'b1;
                        fin_status = ST_OK;
                    end
                end
            end
            PH_P_D1: begin
                if (delay_done) begin
                    scl_next   = 1'b1;
                    delay_next = cfg.half_period;
                    phase_next = PH_P_D2;
                end
            end
            PH_P_D2: begin
                if (delay_done) begin
                    delay_next = '0;
                    sda_next   = 1'b1;
                    fin        = 1'b1;
                    fin_status = pend_reg;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fin) begin
            phase_next = PH_IDLE;
            last_next  = fin_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            bitcnt_reg <= '0;
            sh_reg     <= '0;
            delay_reg  <= '0;
            wait_reg   <= '0;
            flags_reg  <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            last_reg   <= ST_OK;
            pend_reg   <= ST_OK;
            rx_reg     <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            bitcnt_reg <= bitcnt_next;
            sh_reg     <= sh_next;
            delay_reg  <= delay_next;
            wait_reg   <= wait_next;
            flags_reg  <= flags_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            last_reg   <= last_next;
            pend_reg   <= pend_next;
            rx_reg     <= rx_next;
        end
    end

    assign res.scl_out  = scl_next;
    assign res.sda_out  = sda_next;
    assign res.busy_res = phase_next != PH_IDLE;
    assign res.done_res = fin;
    assign res.status   = last_next;
    assign res.rx_byte  = rx_next;

    a_hold_without_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(sh_reg) && $stable(wait_reg))
        else $error("engine state moved without a tick");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.done_res |=> phase_reg == PH_IDLE)
        else $error("finished command did not return to idle");

    a_idle_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_IDLE && !tick.cmd_valid |=> phase_reg == PH_IDLE)
        else $error("engine left idle without a command");

    a_bitcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bitcnt_reg <= BITS_PER_BYTE)
        else $error("bit counter ran past one byte");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the I2C master byte engine top level.
// Depends on rtl/i2cm_pkg.sv and rtl/i2c_master_byte_engine_top.sv; drives ticks from a bus model.
`timescale 1ns / 1ps

module tb_top;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_TICKS    = 10;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_PERIOD;
    logic [CFG_DW-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd_valid = 1'b0;
    logic                 s_action = 1'b0;
    logic [7:0]           s_tx_byte = '0;
    logic                 s_with_start = 1'b0;
    logic                 s_with_stop = 1'b0;
    logic                 s_ack_after_read = 1'b0;
    logic                 s_scl_in = 1'b1;
    logic                 s_sda_in = 1'b1;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_scl_out;
    logic                 m_sda_out;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [1:0]           m_status;
    logic [7:0]           m_rx_byte;

    // engine state mirror
    logic [PHASE_W-1:0] ph;
    logic [3:0]         bit_cnt;
    logic [7:0]         shreg;
    logic [7:0]         rx_hold;
    logic [HALF_W-1:0]  dly;
    logic [HALF_W-1:0]  cfg_half;
    logic [TOCFG_W-1:0] wcnt;
    logic [TOCFG_W-1:0] cfg_limit;
    logic [3:0]         flags;
    logic               drv_scl;
    logic               drv_sda;
    logic [1:0]         last_st;
    logic [1:0]         pend_st;

    res_t expected_q[$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   quiet_cycles = 0;
    int unsigned pace_cnt = 0;

    // bus model knobs, percentages
    int stretch_pct;
    int ack_pct;
    int busy_pct;
    int junk_pct;
    int noise_pct;
    bit hold_scl_low;

    i2c_master_byte_engine_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd_valid     (s_cmd_valid),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_with_start    (s_with_start),
        .s_with_stop     (s_with_stop),
        .s_ack_after_read(s_ack_after_read),
        .s_scl_in        (s_scl_in),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_out       (m_scl_out),
        .m_sda_out       (m_sda_out),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_status        (m_status),
        .m_rx_byte       (m_rx_byte)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void reset_engine_model();
        ph = PH_IDLE;
        bit_cnt = '0;
        shreg = '0;
        rx_hold = '0;
        dly = '0;
        wcnt = '0;
        flags = '0;
        drv_scl = 1'b1;
        drv_sda = 1'b1;
        last_st = ST_OK;
        pend_st = ST_OK;
        cfg_half = HALF_RESET;
        cfg_limit = TIMEOUT_RESET;
    endfunction

    function automatic void load_delay(logic [PHASE_W-1:0] next_ph);
        dly = cfg_half;
        ph = next_ph;
    endfunction

    function automatic bit delay_over();
        if (dly > 16'd1) begin
            dly = dly - 1'b1;
            return 1'b0;
        end
        dly = '0;
        return 1'b1;
    endfunction

    function automatic void start_wait(logic [PHASE_W-1:0] next_ph);
        wcnt = '0;
        ph = next_ph;
    endfunction

    // count one low sample against the timeout
    function automatic bit wait_expired();
        wcnt = wcnt + 1'b1;
        return wcnt >= cfg_limit;
    endfunction

    function automatic void begin_stop(logic [1:0] st);
        pend_st = st;
        drv_sda = 1'b0;
        load_delay(PH_P_D1);
    endfunction

    function automatic void write_bit();
        drv_sda = shreg[7];
        load_delay(PH_W_D1);
    endfunction

    // advance the engine by one tick and return the result beat it produces
    function automatic res_t step_engine(tick_t t);
        res_t r;
        logic fin;
        logic [1:0] fin_st;
        fin = 1'b0;
        fin_st = ST_OK;
        case (ph)
            PH_IDLE: begin
                if (t.cmd_valid) begin
                    bit_cnt = '0;
                    flags = {t.ack_after_read, t.with_stop, t.with_start, t.action};
                    if (t.action) begin
                        shreg = '0;
                        drv_sda = 1'b1;
                        load_delay(PH_R_D1);
                    end else begin
                        shreg = t.tx_byte;
                        if (t.with_start) begin
                            drv_sda = 1'b1;
                            drv_scl = 1'b1;
                            start_wait(PH_BUSWAIT);
                        end else begin
                            write_bit();
                        end
                    end
                end
            end
            PH_BUSWAIT: begin
                if (t.sda_in) begin
                    drv_scl = 1'b1;
                    start_wait(PH_ST_STRETCH);
                end else if (wait_expired()) begin
                    fin = 1'b1;
                    fin_st = ST_TIMEOUT;
                end
            end
            PH_ST_STRETCH: begin
                if (t.scl_in) begin
                    drv_sda = 1'b0;
                    load_delay(PH_ST_D1);
                end else if (wait_expired()) begin
                    begin_stop(ST_TIMEOUT);
                end
            end
            PH_ST_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b0;
                    load_delay(PH_ST_D2);
                end
            end
            PH_ST_D2: begin
                if (delay_over()) write_bit();
            end
            PH_W_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b1;
                    start_wait(PH_W_STRETCH);
                end
            end
            PH_W_STRETCH: begin
                if (t.scl_in) load_delay(PH_W_D2);
                else if (wait_expired()) begin_stop(ST_TIMEOUT);
            end
            PH_W_D2: begin
                if (delay_over()) begin
                    drv_scl = 1'b0;
                    shreg = shreg << 1;
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        drv_sda = 1'b1;
                        load_delay(PH_A_D1);
                    end else begin
                        write_bit();
                    end
                end
            end
            PH_A_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b1;
                    start_wait(PH_A_STRETCH);
                end
            end
            PH_A_STRETCH: begin
                if (t.scl_in) begin
                    drv_scl = 1'b0;
                    if (flags[FL_STOP] || t.sda_in) begin
                        begin_stop(t.sda_in ? ST_NACK : ST_OK);
                    end else begin
                        fin = 1'b1;
                    end
                end else if (wait_expired()) begin
                    begin_stop(ST_TIMEOUT);
                end
            end
            PH_R_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b1;
                    start_wait(PH_R_STRETCH);
                end
            end
            PH_R_STRETCH: begin
                if (t.scl_in) begin
                    shreg = {shreg[6:0], t.sda_in};
                    drv_scl = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        drv_sda = !flags[FL_ACK];
                        load_delay(PH_RA_D1);
                    end else begin
                        load_delay(PH_R_D1);
                    end
                end else if (wait_expired()) begin
                    begin_stop(ST_TIMEOUT);
                end
            end
            PH_RA_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b1;
                    start_wait(PH_RA_STRETCH);
                end
            end
            PH_RA_STRETCH: begin
                if (t.scl_in) load_delay(PH_RA_D2);
                else if (wait_expired()) begin_stop(ST_TIMEOUT);
            end
            PH_RA_D2: begin
                if (delay_over()) begin
                    drv_scl = 1'b0;
                    rx_hold = shreg;
                    if (flags[FL_STOP]) begin
                        begin_stop(ST_OK);
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            PH_P_D1: begin
                if (delay_over()) begin
                    drv_scl = 1'b1;
                    load_delay(PH_P_D2);
                end
            end
            PH_P_D2: begin
                if (delay_over()) begin
                    drv_sda = 1'b1;
                    fin = 1'b1;
                    fin_st = pend_st;
                end
            end
            default: ph = PH_IDLE;
        endcase
        if (fin) begin
            ph = PH_IDLE;
            last_st = fin_st;
        end
        r.scl_out = drv_scl;
        r.sda_out = drv_sda;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = fin;
        r.status = last_st;
        r.rx_byte = rx_hold;
        return r;
    endfunction

    function automatic void set_bus(int stretch, int ack, int busy, int junk, int noise, bit hold);
        stretch_pct = stretch;
        ack_pct = ack;
        busy_pct = busy;
        junk_pct = junk;
        noise_pct = noise;
        hold_scl_low = hold;
    endfunction

    // sample the lines as a target would see them after the current drive
    function automatic tick_t bus_tick();
        tick_t t;
        logic target_sda;
        t = '0;
        t.action = 1'($urandom);
        t.tx_byte = 8'($urandom);
        t.with_start = 1'($urandom);
        t.with_stop = 1'($urandom);
        t.ack_after_read = 1'($urandom);
        t.cmd_valid = (ph != PH_IDLE) && ($urandom_range(0, 99) < junk_pct);
        if ($urandom_range(0, 99) < noise_pct) begin
            t.scl_in = 1'($urandom);
            t.sda_in = 1'($urandom);
            return t;
        end
        target_sda = 1'b1;
        case (ph)
            PH_BUSWAIT:              target_sda = ($urandom_range(0, 99) >= busy_pct);
            PH_A_D1, PH_A_STRETCH:   target_sda = ($urandom_range(0, 99) >= ack_pct);
            PH_R_D1, PH_R_STRETCH:   target_sda = 1'($urandom);
            default:                 target_sda = 1'b1;
        endcase
        t.sda_in = drv_sda & target_sda;
        t.scl_in = drv_scl & !hold_scl_low & ($urandom_range(0, 99) >= stretch_pct);
        return t;
    endfunction

    function automatic tick_t cmd_tick(logic act, logic [7:0] data, logic start_bit,
                                       logic stop_bit, logic ack_bit);
        tick_t t;
        t = bus_tick();
        t.cmd_valid = 1'b1;
        t.action = act;
        t.tx_byte = data;
        t.with_start = start_bit;
        t.with_stop = stop_bit;
        t.ack_after_read = ack_bit;
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_cmd_valid      <= t.cmd_valid;
        s_action         <= t.action;
        s_tx_byte        <= t.tx_byte;
        s_with_start     <= t.with_start;
        s_with_stop      <= t.with_stop;
        s_ack_after_read <= t.ack_after_read;
        s_scl_in         <= t.scl_in;
        s_sda_in         <= t.sda_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(step_engine(t));
    endtask

    // hold the sender until every result has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timing(logic [HALF_W-1:0] half, logic [TOCFG_W-1:0] limit);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HALF_PERIOD;
        cfg_wdata <= {8'($urandom), half};
        @(posedge aclk);
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_half = half;
        cfg_limit = limit;
    endtask

    task automatic run_command(logic act, logic [7:0] data, logic start_bit,
                               logic stop_bit, logic ack_bit);
        send_tick(cmd_tick(act, data, start_bit, stop_bit, ack_bit));
        while (ph != PH_IDLE) send_tick(bus_tick());
    endtask

    task automatic test_reset_defaults();
        set_bus(0, 100, 0, 0, 0, 1'b0);
        run_command(1'b1, 8'hA5, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_write_byte();
        set_timing(16'd1, 24'd4);
        set_bus(0, 100, 0, 0, 0, 1'b0);
        run_command(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1);
        // target answers NACK: stop follows
        set_bus(0, 0, 0, 0, 0, 1'b0);
        run_command(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
        // commands arriving while busy must be dropped
        set_bus(25, 100, 0, 100, 0, 1'b0);
        run_command(1'b0, 8'h80, 1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_read_byte();
        set_bus(0, 100, 0, 0, 0, 1'b0);
        run_command(1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
        run_command(1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
        // clock held low by the target: rx_byte must keep the last good read
        set_bus(0, 100, 0, 0, 0, 1'b1);
        run_command(1'b1, 8'h5A, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic test_bus_timeouts();
        set_bus(0, 100, 100, 0, 0, 1'b0);
        run_command(1'b0, 8'hC3, 1'b1, 1'b1, 1'b0);
        set_bus(0, 100, 0, 0, 0, 1'b1);
        run_command(1'b0, 8'h3C, 1'b1, 1'b0, 1'b0);
        run_command(1'b0, 8'h7E, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_zero_settings();
        set_timing(16'd0, 24'd0);
        set_bus(0, 100, 0, 0, 0, 1'b0);
        run_command(1'b0, 8'($urandom), 1'b1, 1'b1, 1'b0);
        set_bus(50, 100, 30, 0, 0, 1'b0);
        run_command(1'b1, 8'($urandom), 1'b0, 1'b1, 1'b1);
        run_command(1'b0, 8'($urandom), 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_pause_mid_command();
        set_timing(16'd2, 24'd20);
        set_bus(10, 100, 0, 0, 0, 1'b0);
        send_tick(cmd_tick(1'b0, 8'h96, 1'b1, 1'b1, 1'b0));
        repeat (6) send_tick(bus_tick());
        settle();
        while (ph != PH_IDLE) send_tick(bus_tick());
    endtask

    task automatic test_long_half_period();
        set_timing(16'hFFFF, 24'd1);
        set_bus(0, 100, 100, 0, 0, 1'b0);
        run_command(1'b0, 8'hAA, 1'b1, 1'b1, 1'b0);
        // longer delays around a stretch timeout and the stop
        set_timing(16'd12, 24'd1);
        set_bus(0, 100, 0, 5, 0, 1'b1);
        run_command(1'b0, 8'h55, 1'b0, 1'b0, 1'b0);
        set_timing(16'd1, 24'hFFFFFF);
        set_bus(60, 90, 0, 0, 0, 1'b0);
        run_command(1'b0, 8'($urandom), 1'b1, 1'b0, 1'b0);
        run_command(1'b1, 8'($urandom), 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int budget;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       set_timing(16'd1, 24'd3);
                1:       set_timing(16'd2, 24'hFFFFFF);
                2:       set_timing(16'd1, 24'd1);
                3:       set_timing(16'd3, 24'd6);
                default: set_timing(16'($urandom_range(1, 4)), 24'($urandom_range(1, 40)));
            endcase
            set_bus($urandom_range(0, 40), $urandom_range(50, 100), $urandom_range(0, 60),
                    $urandom_range(0, 30), $urandom_range(0, 10), 1'b0);
            budget = PHASE_TICKS;
            while (budget > 0) begin
                if (ph == PH_IDLE && $urandom_range(0, 3) != 0) begin
                    send_tick(cmd_tick(1'($urandom), 8'($urandom),
                                       1'($urandom_range(0, 1)),
                                       ($urandom_range(0, 2) == 0), 1'($urandom)));
                end else begin
                    send_tick(bus_tick());
                end
                budget--;
                if (budget == PHASE_TICKS / 2) settle();
            end
            while (ph != PH_IDLE) send_tick(bus_tick());
        end
    endtask

    // receiver pacing: free-running, random, fixed pattern, heavy stall
    always @(posedge aclk) begin
        pace_cnt <= pace_cnt + 1;
        case ((pace_cnt >> 8) % 4)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ((pace_cnt % 7) < 4);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("scl_out", 8'(want.scl_out), 8'(m_scl_out));
                check_field("sda_out", 8'(want.sda_out), 8'(m_sda_out));
                check_field("busy_res", 8'(want.busy_res), 8'(m_busy_res));
                check_field("done_res", 8'(want.done_res), 8'(m_done_res));
                check_field("status", 8'(want.status), 8'(m_status));
                check_field("rx_byte", want.rx_byte, m_rx_byte);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_engine_model();
        set_bus(0, 100, 0, 0, 0, 1'b0);
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_write_byte();
        test_read_byte();
        test_bus_timeouts();
        test_zero_settings();
        test_pause_mid_command();
        test_long_half_period();
        test_random_traffic();
        settle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
